// ----- sv/rit_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rit_pkg;

    localparam int DEFAULT_DEPTH = 32;

    localparam int ID_W    = 128;
    localparam int HALF_W  = 64;
    localparam int TIME_W  = 32;
    localparam int REQ_W   = 2;
    localparam int SLOT_W  = 5;
    localparam int COUNT_W = 6;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    localparam logic [TIME_W-1:0] TIME_ONES = '1;

    typedef struct packed {
        logic capture;
        logic sweep;
        logic rd_en;
        logic addr_inc;
        logic addr_clr;
        logic commit;
        logic load_out;
    } rit_cmd_t;

    typedef struct packed {
        logic in_is_clear;
        logic addr_last;
        logic out_free;
    } rit_sts_t;

endpackage

`default_nettype wire

// ----- sv/recent_id_table_top.sv -----
// One transaction is worked at a time; the table's single read port is scanned one entry per
// cycle (clear sweeps the write port alike).
// A finished result waits in the output register while the next transaction is taken.
// Reset: asynchronous, active low; a zeroing pass over the whole table follows, in_ready low.
`timescale 1ns / 1ps
`default_nettype none

module recent_id_table_top
    import rit_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_DEPTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [REQ_W-1:0]    req_type,
    input  wire logic [HALF_W-1:0]   id_high,
    input  wire logic [HALF_W-1:0]   id_low,
    input  wire logic [TIME_W-1:0]   now,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     hit,
    output logic [SLOT_W-1:0]        slot_index,
    output logic [COUNT_W-1:0]       used_count,
    output logic [TIME_W-1:0]        oldest_time
);

    rit_cmd_t cmd;
    rit_sts_t sts;

    rit_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rit_dp #(
        .DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req_type),
        .id_high     (id_high),
        .id_low      (id_low),
        .now         (now),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .hit         (hit),
        .slot_index  (slot_index),
        .used_count  (used_count),
        .oldest_time (oldest_time)
    );

endmodule

`default_nettype wire

// ----- sv/rit_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rit_dp
    import rit_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rit_cmd_t            cmd,
    output rit_sts_t                 sts,
    input  wire logic [REQ_W-1:0]    req_type,
    input  wire logic [HALF_W-1:0]   id_high,
    input  wire logic [HALF_W-1:0]   id_low,
    input  wire logic [TIME_W-1:0]   now,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output logic                     hit,
    output logic [SLOT_W-1:0]        slot_index,
    output logic [COUNT_W-1:0]       used_count,
    output logic [TIME_W-1:0]        oldest_time
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // table storage
    logic [ID_W-1:0]   id_mem   [DEPTH];
    logic [TIME_W-1:0] time_mem [DEPTH];

    // captured request
    logic [REQ_W-1:0]  op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] now_reg;

    // scan address and read pipeline
    logic [IDX_W-1:0]  addr_reg;
    logic              rd_vld_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [ID_W-1:0]   rd_id_reg;
    logic [TIME_W-1:0] rd_time_reg;

    // scan accumulators
    logic              found_reg,     found_next;
    logic [IDX_W-1:0]  match_idx_reg, match_idx_next;
    logic [IDX_W-1:0]  min_idx_reg,   min_idx_next;
    logic [TIME_W-1:0] min1_reg,      min1_next;
    logic [TIME_W-1:0] min2_reg,      min2_next;
    logic [CNT_W-1:0]  nz_cnt_reg,    nz_cnt_next;
    logic [TIME_W-1:0] nz_min_reg,    nz_min_next;

    // result registers
    logic              out_valid_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [TIME_W-1:0] oldest_reg;

    logic              is_add;
    logic              replace;
    logic              drop_old;
    logic              now_nz;
    logic              rd_match;
    logic [IDX_W-1:0]  tgt_idx;
    logic [CNT_W-1:0]  base_cnt;
    logic [TIME_W-1:0] base_min;
    logic [CNT_W-1:0]  fin_cnt;
    logic [TIME_W-1:0] fin_min;
    logic              fin_hit;
    logic [IDX_W-1:0]  fin_slot;
    logic [IDX_W+SLOT_W-1:0]  slot_ext;
    logic [CNT_W+COUNT_W-1:0] cnt_ext;

    logic [IDX_W-1:0]  wr_addr;
    logic              id_we;
    logic              time_we;
    logic [ID_W-1:0]   wr_id;
    logic [TIME_W-1:0] wr_time;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= req_type;
            id_reg  <= {id_high, id_low};
            now_reg <= now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg   <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.addr_clr)
                addr_reg <= '0;
            else if (cmd.addr_inc)
                addr_reg <= addr_reg + IDX_W'(1);
            rd_vld_reg <= cmd.rd_en;
        end
    end

    assign is_add   = (op_reg == REQ_ADD);
    assign now_nz   = (now_reg != '0);
    assign rd_match = (rd_id_reg == id_reg);

    always_comb
    begin
        found_next     = found_reg;
        match_idx_next = match_idx_reg;
        min_idx_next   = min_idx_reg;
        min1_next      = min1_reg;
        min2_next      = min2_reg;
        nz_cnt_next    = nz_cnt_reg;
        nz_min_next    = nz_min_reg;
        if (cmd.capture)
        begin
            found_next     = 1'b0;
            match_idx_next = '0;
            min_idx_next   = '0;
            min1_next      = TIME_ONES;
            min2_next      = TIME_ONES;
            nz_cnt_next    = '0;
            nz_min_next    = TIME_ONES;
        end
        else if (rd_vld_reg)
        begin
            if (!found_reg && rd_match)
            begin
                found_next     = 1'b1;
                match_idx_next = rd_idx_reg;
            end
            // keep the two smallest times, duplicates counted; last index wins a tie
            if (rd_time_reg <= min1_reg)
            begin
                min2_next    = min1_reg;
                min1_next    = rd_time_reg;
                min_idx_next = rd_idx_reg;
            end
            else if (rd_time_reg < min2_reg)
                min2_next = rd_time_reg;
            // the entry an add refreshes is accounted for at the end
            if (rd_time_reg != '0 && !(is_add && !found_reg && rd_match))
            begin
                nz_cnt_next = nz_cnt_reg + CNT_W'(1);
                if (rd_time_reg < nz_min_reg)
                    nz_min_next = rd_time_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            found_reg <= 1'b0;
        else
            found_reg <= found_next;
    end

    always_ff @(posedge clk)
    begin
        match_idx_reg <= match_idx_next;
        min_idx_reg   <= min_idx_next;
        min1_reg      <= min1_next;
        min2_reg      <= min2_next;
        nz_cnt_reg    <= nz_cnt_next;
        nz_min_reg    <= nz_min_next;
    end

    // final figures: replacing a used oldest entry removes it from count and minimum
    assign replace  = is_add && !found_reg;
    assign drop_old = replace && (min1_reg != '0);
    assign tgt_idx  = found_reg ? match_idx_reg : min_idx_reg;
    assign base_cnt = drop_old ? (nz_cnt_reg - CNT_W'(1)) : nz_cnt_reg;
    assign base_min = drop_old ? min2_reg : nz_min_reg;

    always_comb
    begin
        if (is_add)
        begin
            fin_cnt = base_cnt + CNT_W'(now_nz);
            fin_min = (now_nz && now_reg < base_min) ? now_reg : base_min;
        end
        else
        begin
            fin_cnt = nz_cnt_reg;
            fin_min = nz_min_reg;
        end
    end

    assign fin_hit  = found_reg && (is_add || op_reg == REQ_LOOKUP);
    assign fin_slot = is_add ? tgt_idx : '0;
    assign slot_ext = {{SLOT_W{1'b0}}, fin_slot};
    assign cnt_ext  = {{COUNT_W{1'b0}}, fin_cnt};

    // table write port: clearing sweep or commit of an add
    assign wr_addr = cmd.sweep ? addr_reg : tgt_idx;
    assign id_we   = cmd.sweep || (cmd.commit && replace);
    assign time_we = cmd.sweep || (cmd.commit && is_add);
    assign wr_id   = cmd.sweep ? '0 : id_reg;
    assign wr_time = cmd.sweep ? '0 : now_reg;

    always_ff @(posedge clk)
    begin
        if (id_we)
            id_mem[wr_addr] <= wr_id;
        if (time_we)
            time_mem[wr_addr] <= wr_time;
        if (cmd.rd_en)
        begin
            rd_id_reg   <= id_mem[addr_reg];
            rd_time_reg <= time_mem[addr_reg];
            rd_idx_reg  <= addr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            hit_reg    <= fin_hit;
            slot_reg   <= slot_ext[SLOT_W-1:0];
            cnt_reg    <= cnt_ext[COUNT_W-1:0];
            oldest_reg <= fin_min;
        end
    end

    assign sts.in_is_clear = (req_type == REQ_CLEAR);
    assign sts.addr_last   = (addr_reg == LAST_IDX);
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign slot_index  = slot_reg;
    assign used_count  = cnt_reg;
    assign oldest_time = oldest_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (nz_cnt_reg <= CNT_W'(DEPTH)))
        else $error("used count accumulator beyond table depth");

    a_empty_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && cnt_reg == '0 && DEPTH < 64) |-> (oldest_reg == TIME_ONES))
        else $error("empty table reports an oldest time");

    a_used_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && cnt_reg != '0) |-> (oldest_reg != '0))
        else $error("used table reports zero oldest time");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> !(id_we || time_we))
        else $error("table read and write in the same cycle");
`endif

endmodule

`default_nettype wire

// ----- sv/rit_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rit_ctrl
    import rit_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire rit_sts_t  sts,
    output rit_cmd_t       cmd
);

    typedef enum logic [5:0] {
        ST_INIT  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_CLEAR = 6'b010000,
        ST_DONE  = 6'b100000
    } rit_state_t;

    rit_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_INIT;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                // zero the whole table after reset
                cmd.sweep    = 1'b1;
                cmd.addr_inc = 1'b1;
                if (sts.addr_last)
                begin
                    cmd.addr_clr = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture  = 1'b1;
                    cmd.addr_clr = 1'b1;
                    state_next   = sts.in_is_clear ? ST_CLEAR : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en    = 1'b1;
                cmd.addr_inc = 1'b1;
                if (sts.addr_last)
                begin
                    cmd.addr_clr = 1'b1;
                    state_next   = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last read word is folded in this cycle
                state_next = ST_DONE;
            end
            ST_CLEAR:
            begin
                cmd.sweep    = 1'b1;
                cmd.addr_inc = 1'b1;
                if (sts.addr_last)
                begin
                    cmd.addr_clr = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // commit is idempotent, so hold it while the result waits
                cmd.commit = 1'b1;
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_SCAN || state_reg == ST_CLEAR))
        else $error("accepted transaction did not start work");

    a_sweep_read: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.sweep && cmd.rd_en))
        else $error("sweep and scan active together");

    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (state_reg == ST_IDLE))
        else $error("result loaded without return to idle");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/recent_id_table_top_tb.sv -----
`timescale 1ns / 1ps

module recent_id_table_top_tb;
    import rit_pkg::*;

    localparam int TABLE_DEPTH = DEFAULT_DEPTH;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int POOL_SIZE      = 48;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    localparam logic [ID_W-1:0] ID_ONES = '1;
    localparam logic [ID_W-1:0] ID_ZERO = '0;
    localparam logic [ID_W-1:0] ID_CHECKER = {64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555};
    localparam logic [ID_W-1:0] ID_CHECKER_INV = ~ID_CHECKER;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] used;
        logic [TIME_W-1:0]  oldest;
    } table_resp_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [REQ_W-1:0]   req_type;
    logic [HALF_W-1:0]  id_high;
    logic [HALF_W-1:0]  id_low;
    logic [TIME_W-1:0]  now;
    logic               out_valid;
    logic               out_ready;
    logic               hit;
    logic [SLOT_W-1:0]  slot_index;
    logic [COUNT_W-1:0] used_count;
    logic [TIME_W-1:0]  oldest_time;

    // shadow copy of the table
    logic [ID_W-1:0]   model_id   [TABLE_DEPTH];
    logic [TIME_W-1:0] model_time [TABLE_DEPTH];
    logic [ID_W-1:0]   id_pool    [POOL_SIZE];

    table_resp_t pending_responses[$];

    logic [TIME_W-1:0] stamp = 32'd1;
    bit no_idle     = 1'b0;
    bit rx_hold_req = 1'b0;
    int mismatches  = 0;
    int compared    = 0;
    int stall_cycles = 0;
    int n_add = 0, n_lookup = 0, n_clear = 0, n_unused = 0, n_hits = 0, n_evict = 0;

    recent_id_table_top #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .id_high     (id_high),
        .id_low      (id_low),
        .now         (now),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .slot_index  (slot_index),
        .used_count  (used_count),
        .oldest_time (oldest_time)
    );

    always #1 clk = ~clk;

    function automatic table_resp_t apply_table_request(input logic [REQ_W-1:0] op,
                                                        input logic [ID_W-1:0] key,
                                                        input logic [TIME_W-1:0] t);
        table_resp_t r;
        logic found;
        logic [TIME_W-1:0] min_t;
        logic [TIME_W-1:0] oldest;
        int min_k;
        int used;
        int k;
        r      = '0;
        found  = 1'b0;
        min_t  = TIME_ONES;
        oldest = TIME_ONES;
        min_k  = 0;
        used   = 0;
        case (op)
            REQ_ADD:
            begin
                n_add++;
                for (k = 0; k < TABLE_DEPTH; k++)
                begin
                    if (!found)
                    begin
                        if (model_id[k] == key)
                        begin
                            model_time[k] = t;
                            r.slot = k[SLOT_W-1:0];
                            found = 1'b1;
                        end
                        else if (model_time[k] <= min_t)
                        begin
                            // later index wins a tie
                            min_t = model_time[k];
                            min_k = k;
                        end
                    end
                end
                if (found)
                    r.hit = 1'b1;
                else
                begin
                    if (model_time[min_k] != '0)
                        n_evict++;
                    model_id[min_k]   = key;
                    model_time[min_k] = t;
                    r.slot = min_k[SLOT_W-1:0];
                end
            end
            REQ_LOOKUP:
            begin
                n_lookup++;
                for (k = 0; k < TABLE_DEPTH; k++)
                    if (model_id[k] == key)
                        r.hit = 1'b1;
            end
            REQ_CLEAR:
            begin
                n_clear++;
                for (k = 0; k < TABLE_DEPTH; k++)
                begin
                    model_id[k]   = '0;
                    model_time[k] = '0;
                end
            end
            default:
                n_unused++;
        endcase
        for (k = 0; k < TABLE_DEPTH; k++)
        begin
            if (model_time[k] != '0)
            begin
                used++;
                if (model_time[k] < oldest)
                    oldest = model_time[k];
            end
        end
        if (r.hit)
            n_hits++;
        r.used   = used[COUNT_W-1:0];
        r.oldest = oldest;
        return r;
    endfunction

    function automatic logic [ID_W-1:0] random_id();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // mostly rising stamps with repeats, now and then zero, all ones or anything
    function automatic logic [TIME_W-1:0] next_stamp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return '0;
        if (r < 4)
            return $urandom;
        if (r < 5)
            return TIME_ONES;
        stamp += $urandom_range(0, 3);
        return stamp;
    endfunction

    task automatic send_req(input logic [REQ_W-1:0] op, input logic [ID_W-1:0] key,
                            input logic [TIME_W-1:0] t);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 40)
            gap = $urandom_range(1, 45);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= op;
        id_high  <= key[ID_W-1:HALF_W];
        id_low   <= key[HALF_W-1:0];
        now      <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_responses.push_back(apply_table_request(op, key, t));
    endtask

    task automatic wait_for_responses();
        in_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic test_directed();
        send_req(REQ_LOOKUP, ID_ZERO, '0);
        send_req(REQ_UNUSED, ID_ZERO, '0);
        send_req(REQ_ADD, ID_ONES, TIME_ONES);
        send_req(REQ_ADD, ID_ZERO, 32'd1);
        send_req(REQ_LOOKUP, ID_ONES, 32'd1);
        send_req(REQ_ADD, ID_CHECKER, 32'd2);
        send_req(REQ_ADD, ID_CHECKER_INV, 32'd3);
        send_req(REQ_ADD, {ID_ONES[ID_W-1:HALF_W], ID_ZERO[HALF_W-1:0]}, 32'd4);
        send_req(REQ_LOOKUP, {ID_ZERO[ID_W-1:HALF_W], ID_ONES[HALF_W-1:0]}, 32'd4);
        // refresh to time zero: entry drops out of the count but keeps its ID
        send_req(REQ_ADD, ID_ONES, '0);
        send_req(REQ_LOOKUP, ID_ONES, 32'd5);
        send_req(REQ_UNUSED, ID_ONES, TIME_ONES);
        send_req(REQ_CLEAR, ID_CHECKER, TIME_ONES);
        send_req(REQ_LOOKUP, ID_ZERO, 32'd5);
        send_req(REQ_ADD, ID_CHECKER, 32'd5);
        send_req(REQ_ADD, ID_ZERO, '0);
        send_req(REQ_ADD, {64'h8000_0000_0000_0000, 64'h1}, TIME_ONES);
        send_req(REQ_LOOKUP, {64'h8000_0000_0000_0000, 64'h1}, 32'd6);
        send_req(REQ_CLEAR, ID_ZERO, '0);
        wait_for_responses();
        stamp = 32'd16;
    endtask

    task automatic test_fill_and_evict();
        int i;
        logic [TIME_W-1:0] t;
        send_req(REQ_CLEAR, ID_ZERO, '0);
        t = stamp + 1;
        // equal stamps, so every replacement here falls to the tie rule
        for (i = 0; i < 40; i++)
            send_req(REQ_ADD, id_pool[i], t);
        for (i = 0; i < 40; i++)
            send_req(REQ_LOOKUP, id_pool[i], t);
        stamp = t;
        for (i = 32; i < 40; i++)
        begin
            stamp = stamp + 32'd1;
            send_req(REQ_ADD, id_pool[i], stamp);
        end
        for (i = 40; i < POOL_SIZE; i++)
        begin
            stamp = stamp + 32'd1;
            send_req(REQ_ADD, id_pool[i], stamp);
        end
        wait_for_responses();
    endtask

    task automatic test_back_pressure();
        int i;
        // hold the receiver while the sender keeps offering back to back
        rx_hold_req = 1'b1;
        no_idle = 1'b1;
        for (i = 0; i < 12; i++)
            send_req(i % 3 == 0 ? REQ_LOOKUP : REQ_ADD,
                     id_pool[$urandom_range(0, POOL_SIZE - 1)], next_stamp());
        no_idle = 1'b0;
        wait_for_responses();
    endtask

    task automatic test_random_mix(input int count);
        int i;
        int r;
        logic [ID_W-1:0] key;
        for (i = 0; i < count; i++)
        begin
            r   = $urandom_range(0, 99);
            key = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            if (r < 52)
                send_req(REQ_ADD, key, next_stamp());
            else if (r < 80)
                send_req(REQ_LOOKUP, key, next_stamp());
            else if (r < 86)
                send_req(REQ_ADD, random_id(), next_stamp());
            else if (r < 92)
                send_req(REQ_LOOKUP, random_id(), next_stamp());
            else if (r < 95)
                send_req(r[0] ? REQ_ADD : REQ_LOOKUP, ID_ZERO, next_stamp());
            else if (r < 98)
                send_req(REQ_UNUSED, random_id(), $urandom);
            else
                send_req(REQ_CLEAR, random_id(), $urandom);
        end
        wait_for_responses();
    endtask

    task automatic test_full_rate();
        no_idle = 1'b1;
        test_random_mix(150);
        no_idle = 1'b0;
    endtask

    initial
    begin : receiver
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else
                out_ready <= no_idle || ($urandom_range(0, 99) >= 25);
        end
    end

    initial
    begin : response_checker
        table_resp_t got;
        table_resp_t want;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got = {hit, slot_index, used_count, oldest_time};
                if (pending_responses.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected transaction: hit %0b slot %0d used %0d oldest %h",
                                 got.hit, got.slot, got.used, got.oldest);
                end
                else
                begin
                    want = pending_responses.pop_front();
                    compared++;
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"mismatch on result %0d: hit %0b/%0b slot %0d/%0d ",
                                      "used %0d/%0d oldest %h/%h (expected/actual)"},
                                     compared, want.hit, got.hit, want.slot, got.slot,
                                     want.used, got.used, want.oldest, got.oldest);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", stall_cycles);
            $display("[recent_id_table_top] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int i;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_ADD;
        id_high  = '0;
        id_low   = '0;
        now      = '0;
        for (i = 0; i < TABLE_DEPTH; i++)
        begin
            model_id[i]   = '0;
            model_time[i] = '0;
        end
        // neighbours share one half so that partial matches are exercised
        for (i = 0; i < POOL_SIZE; i++)
        begin
            id_pool[i] = random_id();
            if (i % 2 == 1)
                id_pool[i][ID_W-1:HALF_W] = id_pool[i-1][ID_W-1:HALF_W];
            else if (i % 4 == 2)
                id_pool[i][HALF_W-1:0] = id_pool[i-2][HALF_W-1:0];
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_fill_and_evict();
        test_back_pressure();
        test_full_rate();
        test_random_mix(760);

        wait_for_responses();
        repeat (TABLE_DEPTH + 4) @(posedge clk);
        $display("requests: %0d add, %0d lookup, %0d clear, %0d unused code; %0d hits, %0d evictions",
                 n_add, n_lookup, n_clear, n_unused, n_hits, n_evict);
        $display("results compared: %0d, mismatches: %0d", compared, mismatches);
        if (mismatches == 0 && pending_responses.size() == 0)
            $display("[recent_id_table_top] OK");
        else
            $display("[recent_id_table_top] ERROR");
        $finish;
    end

endmodule
